// File: rtl/tkm_pkg.sv
package tkm_pkg;

	localparam int TOP_COUNT = 16;
	localparam int IDX_W = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;
	localparam int CNT_W = $clog2(TOP_COUNT + 1);

	localparam logic [1:0] ACT_KEPT     = 2'd0;
	localparam logic [1:0] ACT_INSERTED = 2'd1;
	localparam logic [1:0] ACT_REMOVED  = 2'd2;
	localparam logic [1:0] ACT_END      = 2'd3;

	typedef struct packed {
		logic [63:0] tablet_id;
		logic [31:0] follower_id;
		logic [63:0] metric;
	} entry_t;

	typedef struct packed {
		logic   has_entry;
		logic   end_of_report;
		entry_t ent;
	} item_t;

endpackage

// File: rtl/tkm_if.sv
interface tkm_in_if;
	logic        valid;
	logic        ready;
	logic        has_entry;
	logic [63:0] tablet_id;
	logic [31:0] follower_id;
	logic [63:0] metric;
	logic        end_of_report;

	modport source (output valid, has_entry, tablet_id, follower_id, metric, end_of_report,
		input ready);
	modport sink (input valid, has_entry, tablet_id, follower_id, metric, end_of_report,
		output ready);
endinterface

interface tkm_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [63:0] out_tablet_id;
	logic [31:0] out_follower_id;
	logic [63:0] out_metric;
	logic        is_last;

	modport source (output valid, action, out_tablet_id, out_follower_id, out_metric, is_last,
		input ready);
	modport sink (input valid, action, out_tablet_id, out_follower_id, out_metric, is_last,
		output ready);
endinterface

// File: rtl/tkm_front.sv
module tkm_front (
	input  logic          clk,
	input  logic          arst_n,
	tkm_in_if.sink        in_ch,
	output logic          q_valid,
	input  logic          q_ready,
	output tkm_pkg::item_t q_item
);

	tkm_pkg::item_t mem_q [2];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     cnt_q;
	logic           push;
	logic           pop;
	logic           useful;

	// accept a word whenever the queue has room
	assign in_ch.ready = (cnt_q != 2'd2);
	// drop words that carry neither an entry nor an end
	assign useful = in_ch.has_entry | in_ch.end_of_report;
	assign push   = in_ch.valid & in_ch.ready & useful;
	assign pop    = q_valid & q_ready;

	assign q_valid = (cnt_q != 2'd0);
	assign q_item  = mem_q[rd_q];

	// store the classified word
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= '{has_entry: in_ch.has_entry, end_of_report: in_ch.end_of_report,
				ent: '{tablet_id: in_ch.tablet_id, follower_id: in_ch.follower_id,
				metric: in_ch.metric}};
		end
	end

	// advance queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");
	assert property (@(posedge clk) disable iff (!arst_n) (cnt_q == 2'd0) |-> !pop)
		else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n) (cnt_q == 2'd2) |-> !push)
		else $error("push into full queue");

endmodule

// File: rtl/tkm_back.sv
module tkm_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	output logic           q_ready,
	input  tkm_pkg::item_t q_item,
	tkm_out_if.source      out_ch
);

	typedef enum logic [1:0] {S_IDLE, S_MERGE, S_DRAIN} state_t;

	state_t                     state_q;
	tkm_pkg::item_t             cur_q;
	tkm_pkg::entry_t            ent_q [2][tkm_pkg::TOP_COUNT];
	logic                       bank_q;
	logic [tkm_pkg::CNT_W-1:0]  oc_q;
	logic [tkm_pkg::CNT_W-1:0]  op_q;
	logic [tkm_pkg::CNT_W-1:0]  placed_q;
	logic                       ov_q;
	logic [1:0]                 act_q;
	tkm_pkg::entry_t            oent_q;
	logic                       last_q;

	logic                       out_free;
	logic                       op_lt;
	logic                       full;
	tkm_pkg::entry_t            old_e;
	logic                       old_seen;
	logic                       new_seen;
	logic                       do_place;
	tkm_pkg::entry_t            place_e;

	function automatic logic key_hit(input tkm_pkg::entry_t a, input tkm_pkg::entry_t b);
		return (a.tablet_id == b.tablet_id) && (a.follower_id == b.follower_id);
	endfunction

	assign out_free = !ov_q || out_ch.ready;
	assign op_lt    = op_q < oc_q;
	assign full     = placed_q == tkm_pkg::CNT_W'(tkm_pkg::TOP_COUNT);
	assign old_e    = ent_q[bank_q][op_q[tkm_pkg::IDX_W-1:0]];
	assign q_ready  = (state_q == S_IDLE);

	// check keys placed in this merge, all slots in parallel
	always_comb begin
		old_seen = 1'b0;
		new_seen = 1'b0;
		for (int i = 0; i < tkm_pkg::TOP_COUNT; i++) begin
			if (tkm_pkg::CNT_W'(i) < placed_q) begin
				if (key_hit(ent_q[~bank_q][i], old_e)) old_seen = 1'b1;
				if (key_hit(ent_q[~bank_q][i], cur_q.ent)) new_seen = 1'b1;
			end
		end
	end

	// decide whether this step places an entry in the new list
	always_comb begin
		do_place = 1'b0;
		place_e  = old_e;
		if (out_free) begin
			unique case (state_q)
				S_MERGE: begin
					if (!(op_lt && old_seen) && !new_seen) begin
						do_place = 1'b1;
						if (!(op_lt && old_e.metric >= cur_q.ent.metric)) place_e = cur_q.ent;
					end
				end
				S_DRAIN: do_place = op_lt && !old_seen && !full;
				default: do_place = 1'b0;
			endcase
		end
	end

	// write the new list bank
	always_ff @(posedge clk) begin
		if (do_place) ent_q[~bank_q][placed_q[tkm_pkg::IDX_W-1:0]] <= place_e;
	end

	// sequence the merge and hold the output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			bank_q   <= 1'b0;
			oc_q     <= '0;
			op_q     <= '0;
			placed_q <= '0;
			ov_q     <= 1'b0;
			act_q    <= tkm_pkg::ACT_KEPT;
			last_q   <= 1'b0;
		end else begin
			if (ov_q && out_ch.ready) ov_q <= 1'b0;
			if (do_place) placed_q <= placed_q + 1'b1;
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						cur_q <= q_item;
						if (q_item.has_entry && !full) state_q <= S_MERGE;
						else if (q_item.end_of_report) state_q <= S_DRAIN;
					end
				end
				S_MERGE: begin
					if (out_free) begin
						if (op_lt && old_seen) begin
							op_q <= op_q + 1'b1;
						end else if (new_seen) begin
							state_q <= cur_q.end_of_report ? S_DRAIN : S_IDLE;
						end else if (op_lt && old_e.metric >= cur_q.ent.metric) begin
							op_q   <= op_q + 1'b1;
							ov_q   <= 1'b1;
							act_q  <= tkm_pkg::ACT_KEPT;
							oent_q <= old_e;
							last_q <= 1'b0;
							if (placed_q == tkm_pkg::CNT_W'(tkm_pkg::TOP_COUNT - 1))
								state_q <= cur_q.end_of_report ? S_DRAIN : S_IDLE;
						end else begin
							ov_q    <= 1'b1;
							act_q   <= tkm_pkg::ACT_INSERTED;
							oent_q  <= cur_q.ent;
							last_q  <= 1'b0;
							state_q <= cur_q.end_of_report ? S_DRAIN : S_IDLE;
						end
					end
				end
				S_DRAIN: begin
					if (out_free) begin
						if (op_lt) begin
							op_q <= op_q + 1'b1;
							if (!old_seen) begin
								ov_q   <= 1'b1;
								act_q  <= full ? tkm_pkg::ACT_REMOVED : tkm_pkg::ACT_KEPT;
								oent_q <= old_e;
								last_q <= 1'b0;
							end
						end else begin
							// close the merge and swap list banks
							ov_q     <= 1'b1;
							act_q    <= tkm_pkg::ACT_END;
							oent_q   <= '0;
							last_q   <= 1'b1;
							bank_q   <= ~bank_q;
							oc_q     <= placed_q;
							placed_q <= '0;
							op_q     <= '0;
							state_q  <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_ch.valid           = ov_q;
	assign out_ch.action          = act_q;
	assign out_ch.out_tablet_id   = oent_q.tablet_id;
	assign out_ch.out_follower_id = oent_q.follower_id;
	assign out_ch.out_metric      = oent_q.metric;
	assign out_ch.is_last         = last_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(placed_q <= tkm_pkg::CNT_W'(tkm_pkg::TOP_COUNT)) &&
		(oc_q <= tkm_pkg::CNT_W'(tkm_pkg::TOP_COUNT)))
		else $error("list count past capacity");
	assert property (@(posedge clk) disable iff (!arst_n) op_q <= oc_q)
		else $error("stored pointer past stored count");
	assert property (@(posedge clk) disable iff (!arst_n)
		ov_q |-> (last_q == (act_q == tkm_pkg::ACT_END)))
		else $error("end flag and end action disagree");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAIN && out_free && !op_lt) |=> (placed_q == '0 && op_q == '0))
		else $error("merge state not cleared after end");

endmodule

// File: rtl/top_k_merge_dedup_top.sv
// channel | dir | payload
// in_ch   | in  | has_entry, tablet_id, follower_id, metric, end_of_report
// out_ch  | out | action, out_tablet_id, out_follower_id, out_metric, is_last
//
// An item is loaded from the two-word queue, then the merge sequencer walks stored
// entries and places the insert; an end item then walks each remaining stored entry
// and emits the end marker.
// Reset clears counts and control; list banks hold no reset value and need no clearing.
// A stalled output holds the sequencer; the queue keeps accepting until it holds two words.
module top_k_merge_dedup_top (
	input  logic       clk,
	input  logic       arst_n,
	tkm_in_if.sink     in_ch,
	tkm_out_if.source  out_ch
);

	logic           q_valid;
	logic           q_ready;
	tkm_pkg::item_t q_item;

	tkm_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_item  (q_item)
	);

	tkm_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_item  (q_item),
		.out_ch  (out_ch)
	);

endmodule
